/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/mfmh_pkg.sv */
// shared constants, types and the arctangent table of the field unit
// no dependencies
package mfmh_pkg;

   localparam int GAIN_WIDTH     = 16;
   localparam int MAG_WIDTH      = 20;
   localparam int HEAD_WIDTH     = 15;
   localparam int RSP_DATA_WIDTH = ((MAG_WIDTH + HEAD_WIDTH + 7) / 8) * 8;

   // magnitude path
   localparam int SQRT_FIRST = 3;
   localparam int ROOT_BITS  = MAG_WIDTH;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int PROD_BITS  = 64;
   localparam int DROP_BITS  = 16;

   // heading path
   localparam int CORDIC_STEPS = 21;
   localparam int FRAC_SHIFT   = 24;
   localparam int ANGLE_WIDTH  = 25;
   localparam int HEAD_SHIFT   = 8;

   localparam int PIPE_STAGES = SQRT_FIRST + ROOT_BITS;

   localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd17818;
   localparam logic [MAG_WIDTH-1:0]  MAG_MAX    = 20'hFFFFF;
   localparam logic [HEAD_WIDTH-1:0] HEAD_MAX   = 15'd23040;
   localparam logic [HEAD_WIDTH-1:0] HEAD_POS_X = 15'd11520;
   localparam logic [HEAD_WIDTH-1:0] HEAD_NEG_X = 15'd23040;
   localparam logic [HEAD_WIDTH-1:0] HEAD_POS_Y = 15'd17280;
   localparam logic [HEAD_WIDTH-1:0] HEAD_NEG_Y = 15'd5760;

   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;
   typedef logic [PIPE_STAGES-1:0]        stage_en_type;

   localparam angle_type DEG180     = 25'sd2949120;
   localparam angle_type ROUND_HALF = 25'sd128;

   typedef struct packed {
      logic                sat;
      logic [RAD_BITS-1:0] rad;
   } radicand_type;

   typedef struct packed {
      logic                 sat;
      logic [ROOT_BITS-1:0] root;
   } mag_result_type;

   // atan(2^-step) in 1/16384 degree, rounded to nearest
   function automatic angle_type atan_entry(input logic [4:0] step);
      angle_type value;
      unique case (step)
         5'd0:    value = 25'sd737280;
         5'd1:    value = 25'sd435242;
         5'd2:    value = 25'sd229970;
         5'd3:    value = 25'sd116736;
         5'd4:    value = 25'sd58595;
         5'd5:    value = 25'sd29326;
         5'd6:    value = 25'sd14667;
         5'd7:    value = 25'sd7334;
         5'd8:    value = 25'sd3667;
         5'd9:    value = 25'sd1833;
         5'd10:   value = 25'sd917;
         5'd11:   value = 25'sd458;
         5'd12:   value = 25'sd229;
         5'd13:   value = 25'sd115;
         5'd14:   value = 25'sd57;
         5'd15:   value = 25'sd29;
         5'd16:   value = 25'sd14;
         5'd17:   value = 25'sd7;
         5'd18:   value = 25'sd4;
         5'd19:   value = 25'sd2;
         5'd20:   value = 25'sd1;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

/* rtl/mfmh_norm.sv */
// squares, sum and gain product stages of the magnitude path
// depends on mfmh_pkg
module mfmh_norm import mfmh_pkg::*; #(
   parameter int SAMPLE_WIDTH = 13
) (
   input  logic                           clock,
   input  logic [SQRT_FIRST-1:0]          stage_en,
   input  logic signed [SAMPLE_WIDTH-1:0] field_x,
   input  logic signed [SAMPLE_WIDTH-1:0] field_y,
   input  logic signed [SAMPLE_WIDTH-1:0] field_z,
   input  logic [GAIN_WIDTH-1:0]          gain,
   output radicand_type                   radicand
);

   localparam int SQ_W    = 2 * SAMPLE_WIDTH - 1;
   localparam int SUM_W   = 2 * SAMPLE_WIDTH;
   localparam int GAIN2_W = 2 * GAIN_WIDTH;

   logic signed [2*SAMPLE_WIDTH-1:0] xx, yy, zz;
   logic [SQ_W-1:0]     sq_x_in, sq_y_in, sq_z_in, sq_x_ff, sq_y_ff, sq_z_ff;
   logic [GAIN2_W-1:0]  g2_in, g2_ff, g2_d_ff;
   logic [SUM_W-1:0]    sum_in, sum_ff;
   logic [GAIN2_W+SUM_W-1:0] prod;
   logic [PROD_BITS-1:0]     prod_full;
   radicand_type             radicand_in, radicand_ff;

   // stage 0: squares and gain squared
   assign xx      = field_x * field_x;
   assign yy      = field_y * field_y;
   assign zz      = field_z * field_z;
   assign sq_x_in = xx[SQ_W-1:0];
   assign sq_y_in = yy[SQ_W-1:0];
   assign sq_z_in = zz[SQ_W-1:0];
   assign g2_in   = gain * gain;

   // stage 1: sum of squares
   assign sum_in = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);

   // stage 2: full product, dropped low bits, overflow flag
   assign prod          = g2_d_ff * sum_ff;
   assign prod_full     = PROD_BITS'(prod);
   assign radicand_in.sat = |prod_full[PROD_BITS-1:DROP_BITS+RAD_BITS];
   assign radicand_in.rad = prod_full[DROP_BITS+RAD_BITS-1:DROP_BITS];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         sq_z_ff <= sq_z_in;
         g2_ff   <= g2_in;
      end
      if (stage_en[1]) begin
         sum_ff  <= sum_in;
         g2_d_ff <= g2_ff;
      end
      if (stage_en[2]) begin
         radicand_ff <= radicand_in;
      end
   end

   assign radicand = radicand_ff;

endmodule

/* rtl/mfmh_isqrt.sv */
// pipelined restoring square root, one root bit per stage
// depends on mfmh_pkg
module mfmh_isqrt import mfmh_pkg::*; (
   input  logic                 clock,
   input  logic [ROOT_BITS-1:0] stage_en,
   input  radicand_type         radicand,
   output mag_result_type       result
);

   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS-1];
   logic [RAD_BITS-1:0]  rad_ff  [ROOT_BITS-1];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic                 sat_ff  [ROOT_BITS];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_digit
      logic [REM_BITS-1:0]  rem_src, rem_in;
      logic [RAD_BITS-1:0]  rad_src, rad_in;
      logic [ROOT_BITS-1:0] root_src, root_in;
      logic                 sat_src;
      logic [REM_BITS+1:0]  acc, trial, diff;
      logic                 fits;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand.rad;
         assign sat_src  = radicand.sat;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign sat_src  = sat_ff[k-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign acc     = {rem_src, rad_src[RAD_BITS-1 -: 2]};
      assign trial   = (REM_BITS+2)'({root_src, 2'b01});
      assign fits    = acc >= trial;
      assign diff    = acc - trial;
      assign rem_in  = fits ? diff[REM_BITS-1:0] : acc[REM_BITS-1:0];
      assign root_in = {root_src[ROOT_BITS-2:0], fits};
      assign rad_in  = {rad_src[RAD_BITS-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            root_ff[k] <= root_in;
            sat_ff[k]  <= sat_src;
         end
      end

      // the last digit needs no remainder or radicand
      if (k < ROOT_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               rem_ff[k] <= rem_in;
               rad_ff[k] <= rad_in;
            end
         end
      end
   end

   assign result.sat  = sat_ff[ROOT_BITS-1];
   assign result.root = root_ff[ROOT_BITS-1];

endmodule

/* rtl/mfmh_cordic.sv */
// vectoring cordic heading pipeline: prep, one stage per rotation, rounding
// depends on mfmh_pkg
module mfmh_cordic import mfmh_pkg::*; #(
   parameter int SAMPLE_WIDTH = 13
) (
   input  logic                           clock,
   input  stage_en_type                   stage_en,
   input  logic signed [SAMPLE_WIDTH-1:0] field_x,
   input  logic signed [SAMPLE_WIDTH-1:0] field_y,
   output logic [HEAD_WIDTH-1:0]          heading
);

   localparam int CW = SAMPLE_WIDTH + FRAC_SHIFT + 3;
   localparam int TW = ANGLE_WIDTH - 1 - HEAD_SHIFT;

   typedef struct packed {
      logic                  hit;
      logic [HEAD_WIDTH-1:0] value;
   } head_special_type;

   logic signed [CW-1:0] cx_ff [CORDIC_STEPS];
   logic signed [CW-1:0] cy_ff [CORDIC_STEPS];
   angle_type            ang_ff  [CORDIC_STEPS+1];
   head_special_type     spec_ff [CORDIC_STEPS+1];

   // prep: axis special cases, scaling, fold of the left half plane
   logic signed [CW-1:0] x_scaled, y_scaled, cx0_in, cy0_in;
   angle_type            ang0_in;
   head_special_type     spec0_in;
   logic                 left_half;

   assign x_scaled  = CW'(field_x) <<< FRAC_SHIFT;
   assign y_scaled  = CW'(field_y) <<< FRAC_SHIFT;
   assign left_half = field_x[SAMPLE_WIDTH-1];
   assign cx0_in    = left_half ? -x_scaled : x_scaled;
   assign cy0_in    = left_half ? -y_scaled : y_scaled;
   assign ang0_in   = !left_half ? '0 : (field_y[SAMPLE_WIDTH-1] ? -DEG180 : DEG180);

   always_comb begin
      spec0_in.hit   = 1'b1;
      spec0_in.value = HEAD_POS_X;
      priority if (field_x == '0 && field_y == '0) begin
         spec0_in.value = HEAD_POS_X;
      end else if (field_y == '0) begin
         spec0_in.value = left_half ? HEAD_NEG_X : HEAD_POS_X;
      end else if (field_x == '0) begin
         spec0_in.value = field_y[SAMPLE_WIDTH-1] ? HEAD_NEG_Y : HEAD_POS_Y;
      end else begin
         spec0_in.hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cx_ff[0]   <= cx0_in;
         cy_ff[0]   <= cy0_in;
         ang_ff[0]  <= ang0_in;
         spec_ff[0] <= spec0_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CW-1:0] dx, dy, cx_in, cy_in;
      logic                 up;
      angle_type            ang_in;

      assign dx     = cy_ff[i] >>> i;
      assign dy     = cx_ff[i] >>> i;
      assign up     = !cy_ff[i][CW-1];
      assign cx_in  = up ? cx_ff[i] + dx : cx_ff[i] - dx;
      assign cy_in  = up ? cy_ff[i] - dy : cy_ff[i] + dy;
      assign ang_in = up ? ang_ff[i] + atan_entry(5'(i)) : ang_ff[i] - atan_entry(5'(i));

      always_ff @(posedge clock) begin
         if (stage_en[i+1]) begin
            ang_ff[i+1]  <= ang_in;
            spec_ff[i+1] <= spec_ff[i];
         end
      end

      // the last rotation only delivers its angle
      if (i < CORDIC_STEPS - 1) begin : g_vec
         always_ff @(posedge clock) begin
            if (stage_en[i+1]) begin
               cx_ff[i+1] <= cx_in;
               cy_ff[i+1] <= cy_in;
            end
         end
      end
   end

   // rounding to 1/64 degree with clamp to 0..360
   angle_type             t_sum;
   logic [TW-1:0]         t_div;
   logic [HEAD_WIDTH-1:0] heading_in, heading_ff;

   assign t_sum = ang_ff[CORDIC_STEPS] + DEG180 + ROUND_HALF;
   assign t_div = t_sum[ANGLE_WIDTH-2:HEAD_SHIFT];

   always_comb begin
      priority if (spec_ff[CORDIC_STEPS].hit) begin
         heading_in = spec_ff[CORDIC_STEPS].value;
      end else if (t_sum[ANGLE_WIDTH-1]) begin
         heading_in = '0;
      end else if (t_div > TW'(HEAD_MAX)) begin
         heading_in = HEAD_MAX;
      end else begin
         heading_in = t_div[HEAD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[CORDIC_STEPS+1]) begin
         heading_ff <= heading_in;
      end
   end

   assign heading = heading_ff;

endmodule

/* rtl/magnetic_field_magnitude_heading_unit.sv */
// top level of the magnetometer field magnitude and heading unit
// depends on mfmh_pkg, mfmh_norm, mfmh_isqrt, mfmh_cordic, assert_macros.svh
//
//   port group | role          | payload, lowest bit first
//   req_*      | sample in     | tdata: field_x, field_y, field_z, zero pad
//   rsp_*      | result out    | tdata: magnitude, heading, zero pad
//   csr_*      | gain write    | wdata: magnitude_gain (unsigned q4.12)
//
// one transfer per clock in and out while rsp is not stalled; rsp_tvalid rises once a req
//   transfer has passed the squares, sum and product stages and the 20 root-digit stages,
//   then the output register (the 21 cordic rotations plus prep and rounding
//   match the same 23 stages)
// each stage has its own valid bit; a stall on rsp fills bubbles before it
//   reaches req_tready, so no item is dropped or repeated
// synchronous reset clears the valid bits and loads the gain with 4.35

`include "assert_macros.svh"

module magnetic_field_magnitude_heading_unit import mfmh_pkg::*; #(
   parameter int SAMPLE_WIDTH = 13
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // sample channel
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // field_x, field_y, field_z, zero pad
   input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]          req_tdata,
   // result channel
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // magnitude, heading, zero pad
   output logic [RSP_DATA_WIDTH-1:0]                    rsp_tdata,
   // gain register write
   input  logic                                         csr_wen,
   input  logic [GAIN_WIDTH-1:0]                        csr_wdata
);

   logic signed [SAMPLE_WIDTH-1:0] field_x, field_y, field_z;

   assign field_x = req_tdata[SAMPLE_WIDTH-1:0];
   assign field_y = req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
   assign field_z = req_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];

   // gain register
   logic [GAIN_WIDTH-1:0] gain_in, gain_ff;

   assign gain_in = csr_wen ? csr_wdata : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // stage control: a stage loads when its own or any later slot is free or the output drains
   stage_en_type pipe_valid_in, pipe_valid_ff, stage_en;
   logic         rsp_valid_in, rsp_valid_ff;
   logic         out_en;

   assign out_en = !rsp_valid_ff || rsp_tready;

   always_comb begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
         stage_en[i] = out_en || (|(~pipe_valid_ff & (stage_en_type'('1) << i)));
      end
      pipe_valid_in[0] = stage_en[0] ? req_tvalid : pipe_valid_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         pipe_valid_in[i] = stage_en[i] ? pipe_valid_ff[i-1] : pipe_valid_ff[i];
      end
      rsp_valid_in = out_en ? pipe_valid_ff[PIPE_STAGES-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_tready = stage_en[0];

   // magnitude path: squares, sum, product, then root digits
   radicand_type   radicand;
   mag_result_type mag_result;

   mfmh_norm #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_norm (
      .clock    (clock),
      .stage_en (stage_en[SQRT_FIRST-1:0]),
      .field_x  (field_x),
      .field_y  (field_y),
      .field_z  (field_z),
      .gain     (gain_ff),
      .radicand (radicand)
   );

   mfmh_isqrt u_isqrt (
      .clock    (clock),
      .stage_en (stage_en[PIPE_STAGES-1:SQRT_FIRST]),
      .radicand (radicand),
      .result   (mag_result)
   );

   // heading path, same depth as the magnitude path
   logic [HEAD_WIDTH-1:0] heading;

   mfmh_cordic #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_cordic (
      .clock    (clock),
      .stage_en (stage_en),
      .field_x  (field_x),
      .field_y  (field_y),
      .heading  (heading)
   );

   // output register with magnitude saturation
   logic [MAG_WIDTH-1:0]  magnitude_in, magnitude_ff;
   logic [HEAD_WIDTH-1:0] heading_ff;

   assign magnitude_in = mag_result.sat ? MAG_MAX : mag_result.root;

   always_ff @(posedge clock) begin
      if (out_en) begin
         magnitude_ff <= magnitude_in;
         heading_ff   <= heading;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({heading_ff, magnitude_ff});

   // an empty output register never holds off the sample side
   `ASSERT_IMPLIES(a_ready_when_drained, clock, reset, !rsp_valid_ff, req_tready)
   // back pressure reaches req only when every slot is taken
   `ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, !req_tready, (&pipe_valid_ff) && !out_en)
   // an accepted sample occupies the first stage next cycle
   `ASSERT_NEXT(a_accept_enters_pipe, clock, reset, req_tvalid && req_tready, pipe_valid_ff[0])
   // delivered heading stays within 0..360 degrees
   `ASSERT_IMPLIES(a_heading_in_range, clock, reset, rsp_valid_ff, heading_ff <= HEAD_MAX)

endmodule
